FILE: hdl/ray_segment_nearest_hit_macros.svh
// Assertion macros shared by the RTL
`ifndef RAY_SEGMENT_NEAREST_HIT_MACROS_SVH
`define RAY_SEGMENT_NEAREST_HIT_MACROS_SVH
// implication checked every edge outside reset
`define RSNH_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define RSNH_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: hdl/rsnh_pkg.sv
// Package: widths and defaults for the ray/segment nearest-hit block
`default_nettype none
package rsnh_pkg;
  localparam int unsigned CoordFracBitsDef = 16;
  localparam int unsigned DirFrac          = 14;
  localparam int unsigned DepthW           = 31;
  localparam int unsigned NumW             = 80;  // |num|<<14 fits here
  localparam int unsigned DenW             = 50;  // |den| magnitude
  localparam int unsigned QuotW            = 32;
  localparam logic [1:0]  RegEyeX = 2'd0;
  localparam logic [1:0]  RegEyeY = 2'd1;
  localparam logic [1:0]  RegMaxD = 2'd2;
endpackage
`default_nettype wire

FILE: hdl/rsnh_div.sv
// Restoring divider, one quotient bit per cycle, saturating at 2^31
`default_nettype none
module rsnh_div import rsnh_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [DenW-1:0]   den_i,
  output logic                   done_o,
  output logic [QuotW-1:0]       quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0]  n_q;
  logic [DenW:0]    r_q;
  logic [DenW-1:0]  d_q;
  logic [QuotW-1:0] q_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [DenW:0]    r_sh;
  logic             ge;
  logic [QuotW:0]   q_sh;
  always_comb begin
    r_sh = {r_q[DenW-1:0], n_q[NumW-1]};
    ge   = (r_sh >= {1'b0, d_q});
    q_sh = {q_q, ge};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
        n_q    <= num_i;
        d_q    <= den_i;
        r_q    <= '0;
        q_q    <= '0;
      end else if (busy_q) begin
        n_q   <= n_q << 1;
        r_q   <= ge ? r_sh - {1'b0, d_q} : r_sh;
        q_q   <= (q_sh > (QuotW+1)'(33'h080000000)) ? 32'h80000000 : q_sh[QuotW-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  assign quot_o = q_q;
endmodule
`default_nettype wire

FILE: hdl/ray_segment_nearest_hit.sv
// Top level: nearest ray/segment hit over a stream of segments
//
//  channel  dir  payload
//  s_axis   in   tdata: ray_dx,ray_dy,seg_ax,seg_ay,seg_bx,seg_by,seg_tag; tuser: first; tlast
//  m_axis   out  tdata: hit_depth,hit_x,hit_y,hit_tag,hit_found
//  apb      in   eye_x @0, eye_y @4, max_depth @8
//
// A segment that reaches the divider holds the input from its accept cycle through
// the product states S_M0..S_M5 on one shared 34x33 multiplier, the check state
// S_CHK, the bit-serial divider and, when the hit is nearer, the point states S_PX, S_PY.
// A segment rejected at the check skips the divider. first_of_ray adds the point
// states; last_of_ray adds the output state plus any m_axis stall, during
// which the input is not ready. Reset clears the best hit and registers to zero.
`default_nettype none
module ray_segment_nearest_hit import rsnh_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [175:0] s_axis_tdata,  // dx,dy,ax,ay,bx,by,tag
  input  wire logic         s_axis_tuser,  // first_of_ray
  input  wire logic         s_axis_tlast,  // last_of_ray
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata,  // depth,x,y,tag,found
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  `include "ray_segment_nearest_hit_macros.svh"
  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_CHK, S_DIV, S_PX, S_PY,
    S_OUT
  } state_e;
  state_e state_q;

  logic signed [31:0] eye_x_q, eye_y_q;
  logic [30:0]        max_d_q;
  logic               wr;
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  always_comb begin
    case (paddr[3:2])
      RegEyeX: prdata = eye_x_q;
      RegEyeY: prdata = eye_y_q;
      RegMaxD: prdata = {1'b0, max_d_q};
      default: prdata = '0;
    endcase
  end

  // item registers
  logic signed [15:0] dx_q, dy_q;
  logic signed [32:0] abx_q, aby_q, aex_q, aey_q;
  logic [15:0]        tag_q;
  logic               last_q;
  // best hit
  logic [30:0]        bd_q;
  logic signed [31:0] bx_q, by_q;
  logic [15:0]        bt_q;
  logic               bv_q;
  // accumulators
  logic signed [49:0] den_q, tn_q;
  logic signed [66:0] num_q;
  logic [31:0]        dep_q;   // depth being placed (< 2^31)
  logic               upd_q;   // point update target: 1 = new hit

  // shared multiplier 34x33 signed
  logic signed [33:0] ma;
  logic signed [32:0] mb;
  logic signed [66:0] mp;
  always_comb begin
    ma = '0; mb = '0;
    case (state_q)
      S_M0: begin ma = 34'(aby_q); mb = 33'(dx_q); end
      S_M1: begin ma = 34'(abx_q); mb = 33'(dy_q); end
      S_M2: begin ma = 34'(aey_q); mb = 33'(dx_q); end
      S_M3: begin ma = 34'(aex_q); mb = 33'(dy_q); end
      S_M4: begin ma = 34'(aby_q); mb = aex_q; end
      S_M5: begin ma = 34'(abx_q); mb = aey_q; end
      S_PX: begin ma = $signed({2'b0, dep_q}); mb = 33'(dx_q); end
      S_PY: begin ma = $signed({2'b0, dep_q}); mb = 33'(dy_q); end
      default: ;
    endcase
    mp = 67'(ma) * 67'(mb);
  end

  // point: eye + floor(p / 2^14), saturated
  function automatic logic signed [31:0] place(input logic signed [31:0] e,
                                               input logic signed [66:0] p);
    logic signed [67:0] s;
    s = 68'(e) + 68'(p >>> DirFrac);
    if (s > 68'sd2147483647) return 32'h7fffffff;
    if (s < -68'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  logic               t_ok, n_ok, den_neg;
  logic [66:0]        num_mag;
  logic [DenW-1:0]    den_mag;
  logic               dv_start, dv_done;
  logic [QuotW-1:0]   quot;
  always_comb begin
    den_neg = den_q[49];
    t_ok = den_neg ? (tn_q <= 0 && tn_q >= den_q) : (tn_q >= 0 && tn_q <= den_q);
    n_ok = (num_q == 0) || (num_q[66] == den_neg);
    num_mag = num_q[66] ? 67'(-num_q) : 67'(num_q);
    den_mag = den_neg ? DenW'(-den_q) : DenW'(den_q);
  end
  assign dv_start = (state_q == S_CHK) && den_q != 0 && t_ok && n_ok;

  rsnh_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start),
    .num_i({num_mag[65:0], 14'b0}), .den_i(den_mag),
    .done_o(dv_done), .quot_o(quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {bv_q, bt_q, by_q, bx_q, bd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      eye_x_q <= '0; eye_y_q <= '0; max_d_q <= '0;
      bd_q <= '0; bx_q <= '0; by_q <= '0; bt_q <= '0; bv_q <= 1'b0;
    end else begin
      if (wr) begin
        case (paddr[3:2])
          RegEyeX: eye_x_q <= pwdata;
          RegEyeY: eye_y_q <= pwdata;
          RegMaxD: max_d_q <= pwdata[30:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          dx_q   <= s_axis_tdata[15:0];
          dy_q   <= s_axis_tdata[31:16];
          abx_q  <= 33'($signed(s_axis_tdata[63:32])) - 33'($signed(s_axis_tdata[127:96]));
          aby_q  <= 33'($signed(s_axis_tdata[95:64])) - 33'($signed(s_axis_tdata[159:128]));
          aex_q  <= 33'($signed(s_axis_tdata[63:32])) - 33'(eye_x_q);
          aey_q  <= 33'($signed(s_axis_tdata[95:64])) - 33'(eye_y_q);
          tag_q  <= s_axis_tdata[175:160];
          last_q <= s_axis_tlast;
          if (s_axis_tuser) begin
            bd_q <= max_d_q; bt_q <= '0; bv_q <= 1'b0;
            dep_q <= {1'b0, max_d_q}; upd_q <= 1'b0;
            state_q <= S_PX;  // place max-depth point first
          end else begin
            state_q <= S_M0;
          end
        end
        S_M0: begin den_q <= 50'(mp); state_q <= S_M1; end
        S_M1: begin den_q <= den_q - 50'(mp); state_q <= S_M2; end
        S_M2: begin tn_q <= 50'(mp); state_q <= S_M3; end
        S_M3: begin tn_q <= tn_q - 50'(mp); state_q <= S_M4; end
        S_M4: begin num_q <= mp; state_q <= S_M5; end
        S_M5: begin num_q <= num_q - mp; state_q <= S_CHK; end
        S_CHK: state_q <= dv_start ? S_DIV : (last_q ? S_OUT : S_IDLE);
        S_DIV: if (dv_done) begin
          if (quot < {1'b0, bd_q}) begin
            bd_q <= quot[30:0]; bt_q <= tag_q; bv_q <= 1'b1;
            dep_q <= quot; upd_q <= 1'b1;
            state_q <= S_PX;
          end else begin
            state_q <= last_q ? S_OUT : S_IDLE;
          end
        end
        S_PX: begin bx_q <= place(eye_x_q, mp); state_q <= S_PY; end
        S_PY: begin
          by_q <= place(eye_y_q, mp);
          state_q <= upd_q ? (last_q ? S_OUT : S_IDLE) : S_M0;
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `RSNH_ASSERT_IMP(a_no_ready_busy, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `RSNH_ASSERT_NXT(a_div_start, clk_i, rst_ni, dv_start, state_q == S_DIV)
  `RSNH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire
